// ----- design/triangle_row_span_rasterizer_defines.svh -----
// Assertion macros used by the checker file of the row span rasterizer.
// Both sample on clock and are switched off while reset is high.
`ifndef TRIANGLE_ROW_SPAN_RASTERIZER_DEFINES_SVH
`define TRIANGLE_ROW_SPAN_RASTERIZER_DEFINES_SVH

// Same-cycle implication.
`define TRSR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TRSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/trsr_pkg.sv -----
package trsr_pkg;

   // vertex coordinate width, fixed by the interface
   localparam int COORD_W        = 15;
   // width of a vertex difference
   localparam int DIFF_W         = COORD_W + 1;
   localparam int FRAC_BITS_DEF  = 4;
   localparam int PIXEL_BITS_DEF = 11;
   // setup records buffered between front and back end
   localparam int QUEUE_DEPTH    = 2;

   // width of a pixel-minus-vertex offset in subpixel units
   function automatic int offs_width(input int fb, input int pb);
      return ((pb + fb > COORD_W) ? (pb + fb) : COORD_W) + 1;
   endfunction

   // width of an edge function value, including den - nu - nv
   function automatic int edge_width(input int fb, input int pb);
      return DIFF_W + offs_width(fb, pb) + 3;
   endfunction

   // width of a whole-pixel bounding box coordinate before clipping
   function automatic int box_width(input int pb);
      return ((pb > COORD_W) ? pb : COORD_W) + 1;
   endfunction

   // setup record: empty, den sign, lo, hi, nu, nv, nw, three step terms
   function automatic int rec_width(input int fb, input int pb);
      return 2 + 2 * pb + 3 * edge_width(fb, pb) + 3 * DIFF_W;
   endfunction

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_BBOX,
      FR_OFFS,
      FR_MULT,
      FR_SUM,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DONE
   } back_state_type;

endpackage

// ----- design/triangle_row_span_rasterizer.sv -----
// Row span rasterizer: for one triangle and one pixel row, returns the first
// and last pixel of the row whose sample point lies inside the triangle.
// Request channel (req_*): three vertices in signed fixed point with
// FRAC_BITS fraction bits, and the row. Response channel (rsp_*): found flag,
// span start and end, both zero when nothing is covered. A transfer happens
// on a clock edge with valid high and stall low, on either channel.
// Setup of each triangle runs through capture, bounding box, offsets, six
// products through a single 16 x 16 bit multiplier with the last product
// added after it, edge finish, and hand-off into a 2-entry queue. The scan
// engine then tests one pixel per cycle over the clipped box width, and skips
// the scan when the row misses the box or the triangle has zero area.
// Setup of the next request overlaps the scan of the current one.
// While rsp_stall is high the result holds, the scan engine finishes its row
// and waits, the queue fills, and the front end then keeps req_stall high.
// Synchronous reset empties the queue and drops any pending result.
module triangle_row_span_rasterizer import trsr_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_W-1:0]    req_ax,
   input  logic signed [COORD_W-1:0]    req_ay,
   input  logic signed [COORD_W-1:0]    req_bx,
   input  logic signed [COORD_W-1:0]    req_by_coord,
   input  logic signed [COORD_W-1:0]    req_cx,
   input  logic signed [COORD_W-1:0]    req_cy,
   input  logic signed [PIXEL_BITS-1:0] req_row_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_span_found,
   output logic signed [PIXEL_BITS-1:0] rsp_span_start,
   output logic signed [PIXEL_BITS-1:0] rsp_span_end
);

   localparam int REC_W = rec_width(FRAC_BITS, PIXEL_BITS);

   logic             fq_valid, fq_ready;
   logic [REC_W-1:0] fq_data;
   logic             bq_valid, bq_ready;
   logic [REC_W-1:0] bq_data;

   // triangle setup
   trsr_front #(
      .FRAC_BITS  (FRAC_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_ax       (req_ax),
      .req_ay       (req_ay),
      .req_bx       (req_bx),
      .req_by_coord (req_by_coord),
      .req_cx       (req_cx),
      .req_cy       (req_cy),
      .req_row_y    (req_row_y),
      .q_valid      (fq_valid),
      .q_ready      (fq_ready),
      .q_data       (fq_data)
   );

   // setup records waiting for the scan engine
   trsr_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_data  (bq_data)
   );

   // row scan and result register
   trsr_back #(
      .FRAC_BITS  (FRAC_BITS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (bq_valid),
      .q_ready        (bq_ready),
      .q_data         (bq_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_span_found (rsp_span_found),
      .rsp_span_start (rsp_span_start),
      .rsp_span_end   (rsp_span_end)
   );

endmodule

// ----- design/trsr_front.sv -----
module trsr_front import trsr_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   localparam int REC_W     = rec_width(FRAC_BITS, PIXEL_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_W-1:0]    req_ax,
   input  logic signed [COORD_W-1:0]    req_ay,
   input  logic signed [COORD_W-1:0]    req_bx,
   input  logic signed [COORD_W-1:0]    req_by_coord,
   input  logic signed [COORD_W-1:0]    req_cx,
   input  logic signed [COORD_W-1:0]    req_cy,
   input  logic signed [PIXEL_BITS-1:0] req_row_y,
   output logic                         q_valid,
   input  logic                         q_ready,
   output logic [REC_W-1:0]             q_data
);

   localparam int PD_W   = offs_width(FRAC_BITS, PIXEL_BITS);
   localparam int EW     = edge_width(FRAC_BITS, PIXEL_BITS);
   localparam int BW     = box_width(PIXEL_BITS);
   localparam int PROD_W = DIFF_W + PD_W;
   localparam int PMIN_I = -(1 << (PIXEL_BITS - 1));
   localparam int PMAX_I = (1 << (PIXEL_BITS - 1)) - 1;
   localparam int RND_I  = (1 << FRAC_BITS) - 1;
   localparam logic signed [BW-1:0] PMIN = BW'(PMIN_I);
   localparam logic signed [BW-1:0] PMAX = BW'(PMAX_I);

   // product sequence codes
   localparam logic [2:0] K_AD  = 3'd0;  // den, first term
   localparam logic [2:0] K_BE  = 3'd1;  // den, second term
   localparam logic [2:0] K_AX  = 3'd2;  // nu, x term
   localparam logic [2:0] K_BY  = 3'd3;  // nu, y term
   localparam logic [2:0] K_CX  = 3'd4;  // nv, x term
   localparam logic [2:0] K_DY  = 3'd5;  // nv, y term
   localparam logic [2:0] K_END = 3'd6;

   // truncate a subpixel coordinate toward zero to whole pixels
   function automatic logic signed [BW-1:0] trunc_pix(input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W:0] t;
      t = (COORD_W+1)'(v) + (v[COORD_W-1] ? (COORD_W+1)'(RND_I) : (COORD_W+1)'(0));
      return BW'(t >>> FRAC_BITS);
   endfunction

   function automatic logic signed [COORD_W-1:0] min3(input logic signed [COORD_W-1:0] p,
                                                      input logic signed [COORD_W-1:0] q,
                                                      input logic signed [COORD_W-1:0] r);
      logic signed [COORD_W-1:0] m;
      m = (p < q) ? p : q;
      return (m < r) ? m : r;
   endfunction

   function automatic logic signed [COORD_W-1:0] max3(input logic signed [COORD_W-1:0] p,
                                                      input logic signed [COORD_W-1:0] q,
                                                      input logic signed [COORD_W-1:0] r);
      logic signed [COORD_W-1:0] m;
      m = (p > q) ? p : q;
      return (m > r) ? m : r;
   endfunction

   front_state_type state_ff, state_in;
   logic [2:0]      k_ff, k_in;
   logic            prod_vld_ff, prod_vld_in;
   logic            accept;

   logic signed [COORD_W-1:0]    ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [PIXEL_BITS-1:0] row_ff;
   logic signed [DIFF_W-1:0]     a_ff, b_ff, c_ff, d_ff, e_ff, s_ff;
   logic signed [BW-1:0]         minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic signed [PIXEL_BITS-1:0] lo_ff, hi_ff;
   logic                         empty_ff, neg_ff;
   logic signed [PD_W-1:0]       pxd_ff, pyd_ff;
   logic [2:0]                   prod_idx_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [EW-1:0]         den_ff, nu_ff, nv_ff, nw_ff;

   logic signed [BW-1:0]         lo_c, hi_c, row_c;
   logic signed [PIXEL_BITS-1:0] lo_pix_c;
   logic signed [DIFF_W-1:0]     op1_c;
   logic signed [PD_W-1:0]       op2_c;
   logic signed [PROD_W-1:0]     prod_c;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (req_valid) state_in = FR_BBOX;
         end
         FR_BBOX: state_in = FR_OFFS;
         FR_OFFS: state_in = FR_MULT;
         FR_MULT: begin
            if (k_ff == K_END) state_in = FR_SUM;
         end
         FR_SUM:  state_in = FR_PUSH;
         FR_PUSH: begin
            if (q_ready) state_in = FR_IDLE;
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      q_valid   = 1'b0;
      case (state_ff)
         FR_IDLE: req_stall = 1'b0;
         FR_PUSH: q_valid   = 1'b1;
         default: begin
            req_stall = 1'b1;
            q_valid   = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // product sequence counter and product-valid flag
   always_comb begin
      k_in        = k_ff;
      prod_vld_in = 1'b0;
      if (state_ff == FR_OFFS) begin
         k_in = K_AD;
      end else if (state_ff == FR_MULT && k_ff != K_END) begin
         k_in        = k_ff + 3'd1;
         prod_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FR_IDLE;
         k_ff        <= K_AD;
         prod_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         prod_vld_ff <= prod_vld_in;
      end
   end

   // box clipping to the pixel range
   always_comb begin
      lo_c     = (minx_ff < PMIN) ? PMIN : minx_ff;
      hi_c     = (maxx_ff > PMAX) ? PMAX : maxx_ff;
      row_c    = BW'(row_ff);
      lo_pix_c = PIXEL_BITS'(lo_c);
   end

   // multiplier operand select
   always_comb begin
      case (k_ff)
         K_AD: begin
            op1_c = a_ff;
            op2_c = PD_W'(d_ff);
         end
         K_BE: begin
            op1_c = b_ff;
            op2_c = PD_W'(e_ff);
         end
         K_AX: begin
            op1_c = a_ff;
            op2_c = pxd_ff;
         end
         K_BY: begin
            op1_c = b_ff;
            op2_c = pyd_ff;
         end
         K_CX: begin
            op1_c = c_ff;
            op2_c = pxd_ff;
         end
         K_DY: begin
            op1_c = d_ff;
            op2_c = pyd_ff;
         end
         default: begin
            op1_c = '0;
            op2_c = '0;
         end
      endcase
   end

   assign prod_c = op1_c * op2_c;

   // setup datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         ax_ff  <= req_ax;
         ay_ff  <= req_ay;
         bx_ff  <= req_bx;
         by_ff  <= req_by_coord;
         cx_ff  <= req_cx;
         cy_ff  <= req_cy;
         row_ff <= req_row_y;
      end

      // vertex differences and truncated bounding box
      if (state_ff == FR_BBOX) begin
         a_ff    <= DIFF_W'(by_ff) - DIFF_W'(cy_ff);
         b_ff    <= DIFF_W'(cx_ff) - DIFF_W'(bx_ff);
         c_ff    <= DIFF_W'(cy_ff) - DIFF_W'(ay_ff);
         d_ff    <= DIFF_W'(ax_ff) - DIFF_W'(cx_ff);
         e_ff    <= DIFF_W'(ay_ff) - DIFF_W'(cy_ff);
         s_ff    <= DIFF_W'(ay_ff) - DIFF_W'(by_ff);
         minx_ff <= trunc_pix(min3(ax_ff, bx_ff, cx_ff));
         maxx_ff <= trunc_pix(max3(ax_ff, bx_ff, cx_ff));
         miny_ff <= trunc_pix(min3(ay_ff, by_ff, cy_ff));
         maxy_ff <= trunc_pix(max3(ay_ff, by_ff, cy_ff));
      end

      // clipped row extent and offsets of the first sample point
      if (state_ff == FR_OFFS) begin
         empty_ff <= (lo_c > hi_c) || (row_c < miny_ff) || (row_c > maxy_ff);
         lo_ff    <= lo_pix_c;
         hi_ff    <= PIXEL_BITS'(hi_c);
         pxd_ff   <= (PD_W'(lo_pix_c) <<< FRAC_BITS) - PD_W'(cx_ff);
         pyd_ff   <= (PD_W'(row_ff) <<< FRAC_BITS) - PD_W'(cy_ff);
      end

      // one product per cycle, summed the cycle after
      if (state_ff == FR_MULT) begin
         prod_ff     <= prod_c;
         prod_idx_ff <= k_ff;
      end

      if (prod_vld_ff) begin
         case (prod_idx_ff)
            K_AD:    den_ff <= EW'(prod_ff);
            K_BE:    den_ff <= den_ff + EW'(prod_ff);
            K_AX:    nu_ff  <= EW'(prod_ff);
            K_BY:    nu_ff  <= nu_ff + EW'(prod_ff);
            K_CX:    nv_ff  <= EW'(prod_ff);
            K_DY:    nv_ff  <= nv_ff + EW'(prod_ff);
            default: den_ff <= den_ff;
         endcase
      end

      // edge term nw from den - nu - nv, den sign, and degenerate triangle check
      if (state_ff == FR_SUM) begin
         nw_ff    <= den_ff - nu_ff - nv_ff;
         empty_ff <= empty_ff || (den_ff == '0);
         neg_ff   <= den_ff[EW-1];
      end
   end

   assign q_data = {empty_ff, neg_ff, lo_ff, hi_ff, nu_ff, nv_ff, nw_ff, a_ff, c_ff, s_ff};

endmodule

// ----- design/trsr_queue.sv -----
module trsr_queue import trsr_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != CNT_W'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer wrap and fill count
   always_comb begin
      wr_in  = push ? ((wr_ff == LAST) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? ((rd_ff == LAST) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= in_data;
   end

endmodule

// ----- design/trsr_back.sv -----
module trsr_back import trsr_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int PIXEL_BITS = PIXEL_BITS_DEF,
   localparam int REC_W     = rec_width(FRAC_BITS, PIXEL_BITS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_ready,
   input  logic [REC_W-1:0]             q_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_span_found,
   output logic signed [PIXEL_BITS-1:0] rsp_span_start,
   output logic signed [PIXEL_BITS-1:0] rsp_span_end
);

   localparam int EW = edge_width(FRAC_BITS, PIXEL_BITS);

   // edge value agrees with the sign of the area term, or is zero
   function automatic logic edge_ok(input logic signed [EW-1:0] t, input logic neg);
      return (t == '0) || (t[EW-1] == neg);
   endfunction

   back_state_type state_ff, state_in;
   logic           pop, out_load, covered;
   logic           rsp_valid_ff, rsp_valid_in;

   // setup record fields
   logic                         r_empty, r_neg;
   logic signed [PIXEL_BITS-1:0] r_lo, r_hi;
   logic signed [EW-1:0]         r_nu, r_nv, r_nw;
   logic signed [DIFF_W-1:0]     r_a, r_c, r_s;

   logic                         neg_ff, found_ff;
   logic signed [PIXEL_BITS-1:0] x_ff, hi_ff, first_ff, last_ff;
   logic signed [EW-1:0]         nu_ff, nv_ff, nw_ff, su_ff, sv_ff, sw_ff;
   logic                         out_found_ff;
   logic signed [PIXEL_BITS-1:0] out_start_ff, out_end_ff;

   assign {r_empty, r_neg, r_lo, r_hi, r_nu, r_nv, r_nw, r_a, r_c, r_s} = q_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) state_in = r_empty ? BK_DONE : BK_SCAN;
         end
         BK_SCAN: begin
            if (x_ff == hi_ff) state_in = BK_DONE;
         end
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_ready  = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE: q_ready  = 1'b1;
         BK_DONE: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
            q_ready  = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   assign pop     = q_valid && q_ready;
   assign covered = edge_ok(nu_ff, neg_ff) && edge_ok(nv_ff, neg_ff) && edge_ok(nw_ff, neg_ff);

   // result register: holds while the receiver stalls
   always_comb begin
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_stall) rsp_valid_in = rsp_valid_ff;
      else rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row scan: one pixel per cycle, edge values stepped by addition
   always_ff @(posedge clock) begin
      if (pop) begin
         neg_ff   <= r_neg;
         x_ff     <= r_lo;
         hi_ff    <= r_hi;
         nu_ff    <= r_nu;
         nv_ff    <= r_nv;
         nw_ff    <= r_nw;
         su_ff    <= EW'(r_a) <<< FRAC_BITS;
         sv_ff    <= EW'(r_c) <<< FRAC_BITS;
         sw_ff    <= EW'(r_s) <<< FRAC_BITS;
         found_ff <= 1'b0;
         first_ff <= '0;
         last_ff  <= '0;
      end else if (state_ff == BK_SCAN) begin
         if (covered) begin
            if (!found_ff) first_ff <= x_ff;
            last_ff  <= x_ff;
            found_ff <= 1'b1;
         end
         x_ff  <= x_ff + PIXEL_BITS'(1);
         nu_ff <= nu_ff + su_ff;
         nv_ff <= nv_ff + sv_ff;
         nw_ff <= nw_ff + sw_ff;
      end

      if (out_load) begin
         out_found_ff <= found_ff;
         out_start_ff <= first_ff;
         out_end_ff   <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_found = out_found_ff;
   assign rsp_span_start = out_start_ff;
   assign rsp_span_end   = out_end_ff;

endmodule

// ----- design/trsr_checker.sv -----
`include "triangle_row_span_rasterizer_defines.svh"

module trsr_checker import trsr_pkg::*; #(
   parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_span_found,
   input logic signed [PIXEL_BITS-1:0] rsp_span_start,
   input logic signed [PIXEL_BITS-1:0] rsp_span_end
);

   // a stalled result stays offered and unchanged
   `TRSR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_span_found) && $stable(rsp_span_start) && $stable(rsp_span_end), "stalled result changed")

   // an empty row reports a zero span
   `TRSR_ASSERT_IMPL(a_empty_zero, rsp_valid && !rsp_span_found, rsp_span_start == '0 && rsp_span_end == '0, "empty row with nonzero span")

   // a found span runs left to right
   `TRSR_ASSERT_IMPL(a_span_order, rsp_valid && rsp_span_found, rsp_span_start <= rsp_span_end, "span start right of span end")

endmodule

bind triangle_row_span_rasterizer trsr_checker #(
   .PIXEL_BITS (PIXEL_BITS)
) u_trsr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_span_found (rsp_span_found),
   .rsp_span_start (rsp_span_start),
   .rsp_span_end   (rsp_span_end)
);
